[hw/rtl/lbnms_pkg.sv]
// shared types and constants for the letterbox correction and nms block
// no dependencies; used by lbnms_div, lbnms_ctrl, lbnms_datapath and the top level
package lbnms_pkg;

  localparam int MaxDet     = 64;
  localparam int IdxW       = $clog2(MaxDet);
  localparam int CntW       = IdxW + 1;
  localparam int MaxClasses = 4;
  localparam int ClsW       = 2;
  localparam int ClsCntW    = 3;
  localparam int DimW       = 12;
  localparam int ProdW      = 2 * DimW;
  localparam int QW         = 21;
  localparam int NumW       = 42;
  localparam int EdgeW      = QW + 2;
  localparam int PixMulW    = EdgeW + DimW + 1;
  localparam int PixW       = PixMulW - 17;
  localparam int AreaW      = 42;
  localparam int UniW       = AreaW + 2;
  localparam int InterW     = 2 * (EdgeW + 1);

  localparam logic signed [QW-1:0] QMax = 21'sh0FFFFF;
  localparam logic signed [QW-1:0] QMin = 21'sh100000;

  typedef enum logic [2:0] {
    REG_NET_WIDTH     = 3'd0,
    REG_NET_HEIGHT    = 3'd1,
    REG_IMAGE_WIDTH   = 3'd2,
    REG_IMAGE_HEIGHT  = 3'd3,
    REG_IOU_THRESHOLD = 3'd4,
    REG_CLASS_COUNT   = 3'd5
  } cfg_reg_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_P1,
    OP_P2,
    OP_P3,
    OP_P4,
    OP_DIV,
    OP_WR,
    OP_ZRD,
    OP_ZNEXT,
    OP_E1,
    OP_E2,
    OP_E3,
    OP_SEL_INIT,
    OP_SEL,
    OP_HIT,
    OP_CNEXT,
    OP_SUP,
    OP_FIN
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
    logic thr_zero;
    logic div_done;
    logic scan_end;
    logic pipe_empty;
    logic found;
    logic cls_ok;
    logic class_end;
    logic class_used;
  } dp_status_t;

  function automatic logic [DimW-1:0] dim_of(input logic [DimW-1:0] v);
    return (v == '0) ? DimW'(1) : v;
  endfunction

endpackage

[hw/rtl/lbnms_div.sv]
// iterative signed floor divider with saturation to signed q4.16
// depends on lbnms_pkg; one quotient bit per cycle, and start is taken only in the idle state
module lbnms_div import lbnms_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic signed [NumW-1:0] num,
  input  logic [ProdW-1:0]       den,
  output logic                   done,
  output logic signed [QW-1:0]   quo
);

  typedef enum logic [3:0] {
    DV_IDLE = 4'b0001,
    DV_PREP = 4'b0010,
    DV_RUN  = 4'b0100,
    DV_FIN  = 4'b1000
  } dv_state_t;

  dv_state_t state, state_next;
  logic signed [NumW-1:0] num_q;
  logic [ProdW-1:0] den_q;
  logic neg, big;
  logic [ProdW-1:0] rem;
  logic [QW-1:0] sh;
  logic [4:0] step;
  logic [NumW-1:0] u;
  logic [ProdW:0] trial;
  logic ge;

  // negative numerators use ceil on the magnitude
  always_comb begin
    u = num_q[NumW-1] ? (NumW'(-num_q) + NumW'(den_q) - NumW'(1)) : NumW'(num_q);
    trial = {rem, sh[QW-1]};
    ge = trial >= {1'b0, den_q};
  end

  always_comb begin
    state_next = state;
    case (state)
      DV_IDLE: if (start) state_next = DV_PREP;
      DV_PREP: state_next = DV_RUN;
      DV_RUN:  if (step == 5'(QW - 1)) state_next = DV_FIN;
      DV_FIN:  state_next = DV_IDLE;
      default: state_next = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= (state == DV_FIN);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      DV_IDLE: begin
        if (start) begin
          num_q <= num;
          den_q <= den;
        end
      end
      DV_PREP: begin
        neg <= num_q[NumW-1];
        big <= {3'b0, u[NumW-1:QW]} >= den_q;
        rem <= {3'b0, u[NumW-1:QW]};
        sh <= u[QW-1:0];
        step <= '0;
      end
      DV_RUN: begin
        rem <= ge ? ProdW'(trial - {1'b0, den_q}) : trial[ProdW-1:0];
        sh <= {sh[QW-2:0], ge};
        step <= step + 5'd1;
      end
      DV_FIN: begin
        if (!neg) begin
          quo <= (big || sh[QW-1]) ? QMax : $signed(sh);
        end else begin
          quo <= (big || (sh > 21'h100000)) ? QMin : $signed(QW'(-sh));
        end
      end
      default: ;
    endcase
  end

endmodule

[hw/rtl/lbnms_ctrl.sv]
// sequencer for loading, per-class selection, emission and suppression sweeps
// depends on lbnms_pkg; drives the datapath through dp_cmd_t and reads dp_status_t
module lbnms_ctrl import lbnms_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t sts,
  output dp_cmd_t    cmd,
  output logic       busy
);

  typedef enum logic [17:0] {
    ST_IDLE = 18'd1,
    ST_P1   = 18'd2,
    ST_P2   = 18'd4,
    ST_P3   = 18'd8,
    ST_P4   = 18'd16,
    ST_DGO  = 18'd32,
    ST_DWT  = 18'd64,
    ST_WR   = 18'd128,
    ST_ZRD  = 18'd256,
    ST_ZCHK = 18'd512,
    ST_E1   = 18'd1024,
    ST_E2   = 18'd2048,
    ST_E3   = 18'd4096,
    ST_CLS  = 18'd8192,
    ST_SEL  = 18'd16384,
    ST_SELW = 18'd32768,
    ST_SUP  = 18'd65536,
    ST_FIN  = 18'd131072
  } st_t;

  st_t state, state_next;

  always_comb begin
    state_next = state;
    cmd.op = OP_NONE;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.op = OP_CAPTURE;
          state_next = ST_P1;
        end
      end
      ST_P1: begin
        cmd.op = OP_P1;
        state_next = ST_P2;
      end
      ST_P2: begin
        cmd.op = OP_P2;
        state_next = ST_P3;
      end
      ST_P3: begin
        cmd.op = OP_P3;
        state_next = ST_P4;
      end
      ST_P4: begin
        cmd.op = OP_P4;
        state_next = ST_DGO;
      end
      ST_DGO: begin
        cmd.op = OP_DIV;
        state_next = ST_DWT;
      end
      ST_DWT: begin
        if (sts.div_done) state_next = ST_WR;
      end
      ST_WR: begin
        cmd.op = OP_WR;
        if (!sts.last) state_next = ST_IDLE;
        else if (sts.thr_zero) state_next = ST_ZRD;
        else state_next = ST_CLS;
      end
      ST_ZRD: begin
        if (sts.scan_end) begin
          state_next = ST_FIN;
        end else begin
          cmd.op = OP_ZRD;
          state_next = ST_ZCHK;
        end
      end
      ST_ZCHK: begin
        cmd.op = OP_ZNEXT;
        state_next = sts.cls_ok ? ST_E1 : ST_ZRD;
      end
      ST_E1: begin
        cmd.op = OP_E1;
        state_next = ST_E2;
      end
      ST_E2: begin
        cmd.op = OP_E2;
        state_next = ST_E3;
      end
      ST_E3: begin
        cmd.op = OP_E3;
        state_next = sts.thr_zero ? ST_ZRD : ST_SUP;
      end
      ST_CLS: begin
        if (sts.class_end) begin
          state_next = ST_FIN;
        end else if (sts.class_used) begin
          cmd.op = OP_SEL_INIT;
          state_next = ST_SEL;
        end else begin
          cmd.op = OP_CNEXT;
        end
      end
      ST_SEL: begin
        if (sts.scan_end) state_next = ST_SELW;
        else cmd.op = OP_SEL;
      end
      ST_SELW: begin
        if (sts.found) begin
          cmd.op = OP_HIT;
          state_next = ST_E1;
        end else begin
          cmd.op = OP_CNEXT;
          state_next = ST_CLS;
        end
      end
      ST_SUP: begin
        if (!sts.scan_end) begin
          cmd.op = OP_SUP;
        end else if (sts.pipe_empty) begin
          cmd.op = OP_SEL_INIT;
          state_next = ST_SEL;
        end
      end
      ST_FIN: begin
        cmd.op = OP_FIN;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  assign busy = (state != ST_IDLE);

endmodule

[hw/rtl/lbnms_datapath.sv]
// config registers, detection stores, box correction, selection and iou pipeline
// depends on lbnms_pkg and lbnms_div; driven by lbnms_ctrl
module lbnms_datapath import lbnms_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [15:0]           center_x,
  input  logic [15:0]           center_y,
  input  logic [15:0]           box_width,
  input  logic [15:0]           box_height,
  input  logic [ClsW-1:0]       class_id,
  input  logic [15:0]           score,
  input  logic                  last_detection,
  input  logic                  cfg_valid,
  input  logic [2:0]            cfg_index,
  input  logic [15:0]           cfg_data,
  input  dp_cmd_t               cmd,
  output dp_status_t            sts,
  output logic                  out_valid,
  output logic [ClsW-1:0]       out_class,
  output logic [15:0]           left_px,
  output logic signed [16:0]    right_px,
  output logic [15:0]           top_px,
  output logic signed [16:0]    bottom_px,
  output logic [15:0]           out_score,
  output logic                  last_box
);

  // configuration
  logic [DimW-1:0] net_width, net_height, image_width, image_height;
  logic [15:0] iou_threshold;
  logic [ClsCntW-1:0] class_count;
  logic [DimW-1:0] wd, hd, iwd, ihd;

  always_ff @(posedge clk) begin
    if (rst) begin
      net_width <= 12'd416;
      net_height <= 12'd416;
      image_width <= 12'd416;
      image_height <= 12'd416;
      iou_threshold <= 16'd32768;
      class_count <= 3'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_NET_WIDTH:     net_width <= cfg_data[DimW-1:0];
        REG_NET_HEIGHT:    net_height <= cfg_data[DimW-1:0];
        REG_IMAGE_WIDTH:   image_width <= cfg_data[DimW-1:0];
        REG_IMAGE_HEIGHT:  image_height <= cfg_data[DimW-1:0];
        REG_IOU_THRESHOLD: iou_threshold <= cfg_data;
        REG_CLASS_COUNT:   class_count <= cfg_data[ClsCntW-1:0];
        default: ;
      endcase
    end
  end

  assign wd = dim_of(net_width);
  assign hd = dim_of(net_height);
  assign iwd = dim_of(image_width);
  assign ihd = dim_of(image_height);

  op_t op;
  assign op = cmd.op;

  // load path
  logic [15:0] in_cx, in_cy, in_bw, in_bh, in_score;
  logic [ClsW-1:0] in_cls;
  logic in_last;
  logic [ProdW-1:0] wih, hiw, wb0, a0, hb1, a1, offx, offy;
  logic [ProdW+15:0] px, py, pw, ph;
  logic signed [NumW-1:0] nx, ny, nw, nh;
  logic signed [QW-1:0] qx, qy, qw, qh;
  logic dx_done, dy_done, dw_done, dh_done;
  logic div_go;
  logic case1;

  assign case1 = wih <= hiw;
  assign div_go = (op == OP_DIV);

  always_ff @(posedge clk) begin
    case (op)
      OP_CAPTURE: begin
        in_cx <= center_x;
        in_cy <= center_y;
        in_bw <= box_width;
        in_bh <= box_height;
        in_cls <= class_id;
        in_score <= score;
        in_last <= last_detection;
      end
      OP_P1: begin
        wih <= wd * ihd;
        hiw <= hd * iwd;
      end
      OP_P2: begin
        wb0 <= case1 ? ProdW'(wd) : wih;
        a0 <= case1 ? ProdW'(wd) : hiw;
        hb1 <= case1 ? hiw : ProdW'(hd);
        a1 <= case1 ? wih : ProdW'(hd);
      end
      OP_P3: begin
        px <= in_cx * wb0;
        py <= in_cy * hb1;
        pw <= in_bw * wb0;
        ph <= in_bh * hb1;
        offx <= wb0 - a0;
        offy <= hb1 - a1;
      end
      OP_P4: begin
        nx <= $signed({2'b0, px}) - $signed({3'b0, offx, 15'b0});
        ny <= $signed({2'b0, py}) - $signed({3'b0, offy, 15'b0});
        nw <= $signed({2'b0, pw});
        nh <= $signed({2'b0, ph});
      end
      default: ;
    endcase
  end

  lbnms_div u_div_x (.clk(clk), .rst(rst), .start(div_go), .num(nx), .den(a0),
                     .done(dx_done), .quo(qx));
  lbnms_div u_div_y (.clk(clk), .rst(rst), .start(div_go), .num(ny), .den(a1),
                     .done(dy_done), .quo(qy));
  lbnms_div u_div_w (.clk(clk), .rst(rst), .start(div_go), .num(nw), .den(a0),
                     .done(dw_done), .quo(qw));
  lbnms_div u_div_h (.clk(clk), .rst(rst), .start(div_go), .num(nh), .den(a1),
                     .done(dh_done), .quo(qh));

  // frame control
  logic [CntW-1:0] cnt, idx;
  logic [ClsCntW-1:0] cls_cur;
  logic [MaxDet-1:0] done_flags;
  logic found;
  logic [IdxW-1:0] best;
  logic [15:0] best_score;
  logic sel_v;
  logic mem_we, rd_en;
  logic [IdxW-1:0] rd_addr, rd_idx_q;
  logic [2*QW-1:0] c_q, s_q;
  logic [ClsW+15:0] cs_q;

  logic [2*QW-1:0] center_mem [MaxDet];
  logic [2*QW-1:0] size_mem [MaxDet];
  logic [ClsW+15:0] cs_mem [MaxDet];

  assign mem_we = (op == OP_WR) && !cnt[CntW-1];
  assign rd_en = (op == OP_ZRD) || (op == OP_SEL) || (op == OP_HIT) || (op == OP_SUP);
  assign rd_addr = (op == OP_HIT) ? best : idx[IdxW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      center_mem[cnt[IdxW-1:0]] <= {qx, qy};
      size_mem[cnt[IdxW-1:0]] <= {qw, qh};
      cs_mem[cnt[IdxW-1:0]] <= {in_cls, in_score};
    end
    if (rd_en) begin
      c_q <= center_mem[rd_addr];
      s_q <= size_mem[rd_addr];
      cs_q <= cs_mem[rd_addr];
      rd_idx_q <= rd_addr;
    end
  end

  logic sel_take;
  assign sel_take = sel_v && (cs_q[ClsW+15:16] == cls_cur[ClsW-1:0]) &&
                    !done_flags[rd_idx_q] && (!found || (cs_q[15:0] > best_score));

  // iou pipeline stage registers
  logic s1_v, s2_v, s3_v, s4_v, s5_v, s6_v, s7_v;
  logic [IdxW-1:0] s2_idx, s3_idx, s4_idx, s5_idx, s6_idx, s7_idx;
  logic supp;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      idx <= '0;
      cls_cur <= '0;
      found <= 1'b0;
      sel_v <= 1'b0;
      done_flags <= '0;
    end else begin
      sel_v <= (op == OP_SEL);
      case (op)
        OP_WR: begin
          if (!cnt[CntW-1]) cnt <= cnt + CntW'(1);
          idx <= '0;
          cls_cur <= '0;
        end
        OP_ZNEXT, OP_SEL, OP_SUP: idx <= idx + CntW'(1);
        OP_SEL_INIT: begin
          idx <= '0;
          found <= 1'b0;
        end
        OP_HIT: begin
          idx <= '0;
          done_flags[best] <= 1'b1;
        end
        OP_CNEXT: cls_cur <= cls_cur + ClsCntW'(1);
        OP_FIN: begin
          cnt <= '0;
          done_flags <= '0;
        end
        default: ;
      endcase
      if (sel_take) found <= 1'b1;
      if (supp) done_flags[s7_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sel_take) begin
      best <= rd_idx_q;
      best_score <= cs_q[15:0];
    end
  end

  // edges in doubled units
  function automatic logic signed [EdgeW-1:0] edge_of(input logic [QW-1:0] c,
                                                       input logic [QW-1:0] s,
                                                       input logic hi);
    logic signed [EdgeW-1:0] c2, s2;
    c2 = $signed({c[QW-1], c, 1'b0});
    s2 = $signed({{2{s[QW-1]}}, s});
    return hi ? (c2 + s2) : (c2 - s2);
  endfunction

  // truncation toward zero of a product over 131072
  function automatic logic signed [PixW-1:0] px_of(input logic signed [PixMulW-1:0] p);
    logic signed [PixMulW-1:0] adj;
    adj = p + (p[PixMulW-1] ? PixMulW'(131071) : PixMulW'(0));
    return adj[PixMulW-1:17];
  endfunction

  // emission: e_* also hold the kept box for the suppression sweep
  logic signed [EdgeW-1:0] e_l, e_r, e_t, e_b;
  logic [QW-2:0] e_w, e_h;
  logic [ClsW-1:0] e_cls;
  logic [15:0] e_score;
  logic signed [PixMulW-1:0] m_l, m_r, m_t, m_b;
  logic [AreaW-1:0] a_area;
  logic signed [PixW-1:0] l19, r19, t19, b19, iw19, ih19;

  always_ff @(posedge clk) begin
    case (op)
      OP_E1: begin
        e_l <= edge_of(c_q[2*QW-1:QW], s_q[2*QW-1:QW], 1'b0);
        e_r <= edge_of(c_q[2*QW-1:QW], s_q[2*QW-1:QW], 1'b1);
        e_t <= edge_of(c_q[QW-1:0], s_q[QW-1:0], 1'b0);
        e_b <= edge_of(c_q[QW-1:0], s_q[QW-1:0], 1'b1);
        e_w <= s_q[2*QW-2:QW];
        e_h <= s_q[QW-2:0];
        e_cls <= cs_q[ClsW+15:16];
        e_score <= cs_q[15:0];
      end
      OP_E2: begin
        m_l <= e_l * $signed({1'b0, iwd});
        m_r <= e_r * $signed({1'b0, iwd});
        m_t <= e_t * $signed({1'b0, ihd});
        m_b <= e_b * $signed({1'b0, ihd});
        a_area <= {(2*(QW-1))'(e_w) * (2*(QW-1))'(e_h), 2'b00};
      end
      default: ;
    endcase
  end

  assign l19 = px_of(m_l);
  assign r19 = px_of(m_r);
  assign t19 = px_of(m_t);
  assign b19 = px_of(m_b);
  assign iw19 = $signed(PixW'(iwd));
  assign ih19 = $signed(PixW'(ihd));

  // one result held back so the final one can carry last_box
  logic pd_valid;
  logic [ClsW-1:0] pd_cls;
  logic [15:0] pd_l, pd_t, pd_score;
  logic [16:0] pd_r, pd_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      pd_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= ((op == OP_E3) || (op == OP_FIN)) && pd_valid;
      if (op == OP_E3) begin
        pd_valid <= 1'b1;
      end else if (op == OP_FIN) begin
        pd_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_E3 || op == OP_FIN) begin
      out_class <= pd_cls;
      left_px <= pd_l;
      right_px <= $signed(pd_r);
      top_px <= pd_t;
      bottom_px <= $signed(pd_b);
      out_score <= pd_score;
      last_box <= (op == OP_FIN);
    end
    if (op == OP_E3) begin
      pd_cls <= e_cls;
      pd_l <= l19[PixW-1] ? 16'd0 : l19[15:0];
      pd_r <= (r19 > iw19) ? iw19[16:0] : r19[16:0];
      pd_t <= t19[PixW-1] ? 16'd0 : t19[15:0];
      pd_b <= (b19 > ih19) ? ih19[16:0] : b19[16:0];
      pd_score <= e_score;
    end
  end

  // suppression sweep against the kept box
  logic signed [EdgeW-1:0] b_l, b_r, b_t, b_b;
  logic signed [EdgeW-1:0] i_l, i_r, i_t, i_b;
  logic [2*(QW-1)-1:0] s2_wh;
  logic [AreaW-1:0] s3_area, s4_area, s5_area;
  logic s4_ovl, s5_ovl, s6_ovl, s7_ovl;
  logic [EdgeW:0] s4_dx, s4_dy;
  logic [InterW-1:0] s5_inter, s6_inter, s7_inter;
  logic [UniW-1:0] s6_uni;
  logic [37:0] s7_lo, s7_hi;
  logic [59:0] rhs;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
      s6_v <= 1'b0;
      s7_v <= 1'b0;
    end else begin
      s1_v <= (op == OP_SUP);
      s2_v <= s1_v && (cs_q[ClsW+15:16] == cls_cur[ClsW-1:0]) && !done_flags[rd_idx_q];
      s3_v <= s2_v;
      s4_v <= s3_v;
      s5_v <= s4_v;
      s6_v <= s5_v;
      s7_v <= s6_v;
    end
  end

  always_ff @(posedge clk) begin
    b_l <= edge_of(c_q[2*QW-1:QW], s_q[2*QW-1:QW], 1'b0);
    b_r <= edge_of(c_q[2*QW-1:QW], s_q[2*QW-1:QW], 1'b1);
    b_t <= edge_of(c_q[QW-1:0], s_q[QW-1:0], 1'b0);
    b_b <= edge_of(c_q[QW-1:0], s_q[QW-1:0], 1'b1);
    s2_wh <= s_q[2*QW-2:QW] * s_q[QW-2:0];
    s2_idx <= rd_idx_q;

    i_l <= (e_l > b_l) ? e_l : b_l;
    i_r <= (e_r < b_r) ? e_r : b_r;
    i_t <= (e_t > b_t) ? e_t : b_t;
    i_b <= (e_b < b_b) ? e_b : b_b;
    s3_area <= {s2_wh, 2'b00};
    s3_idx <= s2_idx;

    s4_ovl <= !((i_t > i_b) || (i_l > i_r));
    s4_dx <= $unsigned($signed({i_r[EdgeW-1], i_r}) - $signed({i_l[EdgeW-1], i_l}));
    s4_dy <= $unsigned($signed({i_b[EdgeW-1], i_b}) - $signed({i_t[EdgeW-1], i_t}));
    s4_area <= s3_area;
    s4_idx <= s3_idx;

    s5_inter <= s4_dx * s4_dy;
    s5_area <= s4_area;
    s5_ovl <= s4_ovl;
    s5_idx <= s4_idx;

    s6_uni <= UniW'(a_area) + UniW'(s5_area) - s5_inter[UniW-1:0];
    s6_inter <= s5_inter;
    s6_ovl <= s5_ovl;
    s6_idx <= s5_idx;

    s7_lo <= iou_threshold * s6_uni[21:0];
    s7_hi <= iou_threshold * s6_uni[UniW-1:22];
    s7_inter <= s6_inter;
    s7_ovl <= s6_ovl;
    s7_idx <= s6_idx;
  end

  assign rhs = {s7_hi, 22'b0} + 60'(s7_lo);
  assign supp = s7_v && s7_ovl && ({s7_inter, 16'b0} > {4'b0, rhs});

  assign sts.last = in_last;
  assign sts.thr_zero = (iou_threshold == 16'd0);
  assign sts.div_done = dx_done && dy_done && dw_done && dh_done;
  assign sts.scan_end = (idx == cnt);
  assign sts.pipe_empty = !(s1_v || s2_v || s3_v || s4_v || s5_v || s6_v || s7_v);
  assign sts.found = found;
  assign sts.cls_ok = {1'b0, cs_q[ClsW+15:16]} < class_count;
  assign sts.class_end = (cls_cur == ClsCntW'(MaxClasses));
  assign sts.class_used = cls_cur < class_count;

endmodule

[hw/rtl/letterbox_box_correct_nms.sv]
// letterbox box correction with greedy per-class iou suppression, top level
// a detection keeps busy high until it is stored, a wait set by the four dividers;
// the next is taken only once busy falls; after the last detection, each used class gets
// selection passes over the n boxes and each kept box is emitted and swept; zero threshold
// emits used classes in load order, no sweep; results come one per strobe, no backpressure;
// reset is synchronous, active high, and restores the register defaults and an empty frame
module letterbox_box_correct_nms import lbnms_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [15:0]         center_x,
  input  logic [15:0]         center_y,
  input  logic [15:0]         box_width,
  input  logic [15:0]         box_height,
  input  logic [ClsW-1:0]     class_id,
  input  logic [15:0]         score,
  input  logic                last_detection,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output logic                out_valid,
  output logic [ClsW-1:0]     out_class,
  output logic [15:0]         left_px,
  output logic signed [16:0]  right_px,
  output logic [15:0]         top_px,
  output logic signed [16:0]  bottom_px,
  output logic [15:0]         out_score,
  output logic                last_box
);

  dp_cmd_t cmd;
  dp_status_t sts;

  assign cfg_ready = 1'b1;

  lbnms_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .sts(sts), .cmd(cmd), .busy(busy)
  );

  lbnms_datapath u_dp (
    .clk(clk), .rst(rst),
    .center_x(center_x), .center_y(center_y),
    .box_width(box_width), .box_height(box_height),
    .class_id(class_id), .score(score), .last_detection(last_detection),
    .cfg_valid(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd), .sts(sts),
    .out_valid(out_valid), .out_class(out_class),
    .left_px(left_px), .right_px(right_px), .top_px(top_px), .bottom_px(bottom_px),
    .out_score(out_score), .last_box(last_box)
  );

endmodule
